// File: src/opb_pkg.sv
package opb_pkg;

	// item and result field widths
	localparam int X_W         = 32;
	localparam int X_FRAC_BITS = 24;
	localparam int P_W         = 64;
	localparam int HALF_W      = P_W / 2;
	localparam int IDX_W       = 5;
	localparam int BASIS_W     = 3;
	localparam int DEGREE_W    = 5;

	// highest degree the cell row can reach
	localparam int MAX_DEGREE = 31;
	localparam int DEG_W      = $clog2(MAX_DEGREE + 1);

	// coefficient formats (Q2.30)
	localparam int Q_FRAC = 30;
	localparam int Q_W    = 32;
	localparam int AL_W   = Q_FRAC + 3;
	localparam int GA_W   = $clog2(2 * MAX_DEGREE) + Q_FRAC + 1;

	// factor t = alpha*x + beta, and the exact accumulator
	localparam int AX_W   = AL_W + X_W;
	localparam int T_W    = AX_W - X_FRAC_BITS;
	localparam int ACC_W  = T_W + P_W + 2;
	localparam int HI_LSB = Q_FRAC + P_W - 1;

	// APB register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_BASIS  = 1'b0;
	localparam logic REG_DEGREE = 1'b1;

	localparam logic signed [AL_W-1:0]  AL_ONE  = AL_W'(1) <<< Q_FRAC;
	localparam logic signed [AL_W-1:0]  AL_TWO  = AL_W'(2) <<< Q_FRAC;
	localparam logic [Q_W-1:0]          Q30_ONE = Q_W'(1) << Q_FRAC;
	localparam logic signed [AX_W-1:0]  AX_RND  = AX_W'(1) <<< (X_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (Q_FRAC - 1);
	localparam logic signed [P_W-1:0]   ONE_Q32 = P_W'(1) <<< HALF_W;
	localparam logic signed [P_W-1:0]   P_MAX   = {1'b0, {(P_W-1){1'b1}}};
	localparam logic signed [P_W-1:0]   P_MIN   = {1'b1, {(P_W-1){1'b0}}};

	typedef enum logic [BASIS_W-1:0] {
		BASIS_CHEB  = 3'd0,
		BASIS_LEG   = 3'd1,
		BASIS_HERM  = 3'd2,
		BASIS_HERME = 3'd3,
		BASIS_LAG   = 3'd4
	} basis_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_P0,
		S_P1,
		S_RUN
	} state_t;

	// per-cell constants for recurrence step j
	typedef struct packed {
		logic [DEG_W-1:0] j;
		logic [Q_W-1:0]   lg_al;  // (2j+1)/(j+1)
		logic [Q_W-1:0]   gam;    // j/(j+1)
		logic [Q_W-1:0]   inv;    // 1/(j+1)
	} coef_t;

	// token handed from cell to cell
	typedef struct packed {
		logic                  valid;
		logic signed [P_W-1:0] cur;
		logic signed [P_W-1:0] prev;
		logic                  sat;
	} tok_t;

	// unused codes fall back to Chebyshev
	function automatic basis_t basis_decode(input logic [BASIS_W-1:0] raw);
		basis_t b;
		case (raw)
			BASIS_LEG:   b = BASIS_LEG;
			BASIS_HERM:  b = BASIS_HERM;
			BASIS_HERME: b = BASIS_HERME;
			BASIS_LAG:   b = BASIS_LAG;
			default:     b = BASIS_CHEB;
		endcase
		return b;
	endfunction

endpackage

// File: src/opb_if.sv
interface opb_in_if import opb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [X_W-1:0] x_value;

	modport source(output valid, output x_value, input ready);
	modport sink(input valid, input x_value, output ready);
endinterface

interface opb_out_if import opb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [P_W-1:0] poly_value;
	logic [IDX_W-1:0]      degree_index;
	logic                  last;
	logic                  saturated;

	modport source(output valid, output poly_value, output degree_index,
		output last, output saturated, input ready);
	modport sink(input valid, input poly_value, input degree_index,
		input last, input saturated, output ready);
endinterface

// File: src/opb_cell.sv
module opb_cell import opb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  basis_t                basis,
	input  logic signed [X_W-1:0] x,
	input  coef_t                 coef,
	input  tok_t                  tok_i,
	output tok_t                  tok_o
);

	logic signed [AL_W-1:0] al;
	logic signed [AL_W-1:0] be;
	logic signed [GA_W-1:0] ga;

	logic signed [AX_W-1:0] ax_q;
	logic signed [AX_W-1:0] ax_sh;
	logic signed [T_W-1:0]  t_q;
	logic signed [GA_W-1:0] ga_q;

	logic                             v_s1;
	logic                             sat_s1;
	logic signed [P_W-1:0]            prev_s1;
	logic signed [T_W+HALF_W-1:0]     pp_th_s1;
	logic signed [T_W+HALF_W:0]       pp_tl_s1;
	logic signed [GA_W+HALF_W-1:0]    pp_gh_s1;
	logic signed [GA_W+HALF_W:0]      pp_gl_s1;

	logic signed [ACC_W-1:0] acc;
	logic                    fit;
	logic signed [P_W-1:0]   nxt;
	logic                    v_s2;
	logic signed [P_W-1:0]   cur_s2;
	logic signed [P_W-1:0]   prev_s2;
	logic                    sat_s2;

	always_comb begin
		al = AL_TWO;
		be = '0;
		ga = -$signed(GA_W'(Q30_ONE));
		case (basis)
			BASIS_LEG: begin
				al = AL_W'(coef.lg_al);
				ga = -$signed(GA_W'(coef.gam));
			end
			BASIS_HERM: begin
				al = AL_TWO;
				ga = -$signed(GA_W'(coef.j) << (Q_FRAC + 1));
			end
			BASIS_HERME: begin
				al = AL_ONE;
				ga = -$signed(GA_W'(coef.j) << Q_FRAC);
			end
			BASIS_LAG: begin
				al = -$signed(AL_W'(coef.inv));
				be = AL_W'(coef.lg_al);
				ga = -$signed(GA_W'(coef.gam));
			end
			default: begin
				al = AL_TWO;
				ga = -$signed(GA_W'(Q30_ONE));
			end
		endcase
	end

	// t only depends on x and the basis; alpha*x is registered in ax_q, then t in t_q
	assign ax_sh = (ax_q + AX_RND) >>> X_FRAC_BITS;

	always_ff @(posedge clk) begin
		ax_q <= al * x;
		t_q  <= ax_sh[T_W-1:0] + {{(T_W-AL_W){be[AL_W-1]}}, be};
		ga_q <= ga;
	end

	// multiply stage: partial products over the two halves of P(j), P(j-1)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_s1   <= tok_i.sat;
			prev_s1  <= tok_i.cur;
			pp_th_s1 <= t_q * $signed(tok_i.cur[P_W-1:HALF_W]);
			pp_tl_s1 <= t_q * $signed({1'b0, tok_i.cur[HALF_W-1:0]});
			pp_gh_s1 <= ga_q * $signed(tok_i.prev[P_W-1:HALF_W]);
			pp_gl_s1 <= ga_q * $signed({1'b0, tok_i.prev[HALF_W-1:0]});
		end
	end

	// accumulate, round half up, clip to Q32.32
	always_comb begin
		acc = (ACC_W'(pp_th_s1) <<< HALF_W) + ACC_W'(pp_tl_s1)
			+ (ACC_W'(pp_gh_s1) <<< HALF_W) + ACC_W'(pp_gl_s1) + ACC_RND;
		fit = (&acc[ACC_W-1:HI_LSB]) | ~(|acc[ACC_W-1:HI_LSB]);
		if (fit) begin
			nxt = acc[HI_LSB:Q_FRAC];
		end else if (acc[ACC_W-1]) begin
			nxt = P_MIN;
		end else begin
			nxt = P_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s2  <= nxt;
			prev_s2 <= prev_s1;
			sat_s2  <= sat_s1 | ~fit;
		end
	end

	assign tok_o = '{valid: v_s2, cur: cur_s2, prev: prev_s2, sat: sat_s2};

endmodule

// File: src/orthopoly_basis_evaluator.sv
// Orthogonal polynomial basis evaluator. Each accepted sample x (signed Q8.24)
// yields P0(x) .. Pd(x) of the family chosen in the basis register, one result
// item per degree in rising order, d being the degree register; each value is
// signed Q32.32, clipped at the ends of that range, and the saturated bit stays
// set from the first clip to the end of the sample. One sample is worked on at
// a time: P0 and P1 come straight from the sequencer, P1 then seeds the row,
// and every further degree passes through one cell (its multiply stage and
// its accumulate/clip stage); the whole row holds while the result side stalls.
// The next sample is taken once the last result of the current one has
// reached the output register. Write basis and degree only while the block
// is idle; unused basis codes act as Chebyshev.
module orthopoly_basis_evaluator import opb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	opb_in_if.sink             sample,
	opb_out_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// configuration registers
	logic [BASIS_W-1:0]  basis_q;
	logic [DEGREE_W-1:0] degree_q;
	basis_t              basis;
	logic [DEG_W-1:0]    d_eff;
	logic                reg_sel;

	// sequencer and sample
	state_t                state_q, state_d;
	logic signed [X_W-1:0] x_q;
	logic signed [P_W-1:0] xq;
	logic signed [P_W-1:0] p1;
	tok_t                  seed;
	logic                  seed_v_q;
	logic signed [P_W-1:0] seed_cur_q;
	logic                  adv;

	// cell row
	tok_t  tok_i [2:MAX_DEGREE];
	tok_t  tok_o [2:MAX_DEGREE];
	coef_t cf    [2:MAX_DEGREE];
	logic [MAX_DEGREE:2] cell_vld;

	// result source and output register
	logic                  src_v;
	logic signed [P_W-1:0] src_val;
	logic [IDX_W-1:0]      src_idx;
	logic                  src_last;
	logic                  src_sat;
	logic                  out_v_q;
	logic signed [P_W-1:0] poly_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  last_q;
	logic                  sat_q;

	//------------------------------------------------------------------
	// APB registers: basis at 0, degree at 4; low address bits ignored
	//------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_q  <= '0;
			degree_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_BASIS:  basis_q  <= pwdata[BASIS_W-1:0];
				REG_DEGREE: degree_q <= pwdata[DEGREE_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_BASIS:  prdata = PDATA_W'(basis_q);
			REG_DEGREE: prdata = PDATA_W'(degree_q);
			default:    prdata = '0;
		endcase
	end

	assign basis = basis_decode(basis_q);
	assign d_eff = (32'(degree_q) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(degree_q);

	//------------------------------------------------------------------
	// Handshakes. The whole row moves only when the output register can
	// take whatever arrives at it.
	//------------------------------------------------------------------
	assign adv          = !out_v_q || result.ready;
	assign sample.ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			x_q <= sample.x_value;
		end
	end

	// P1 = a1*x + b1, exact: x moved to Q32.32 first
	always_comb begin
		xq = P_W'(x_q) <<< (HALF_W - X_FRAC_BITS);
		case (basis)
			BASIS_HERM: p1 = xq <<< 1;
			BASIS_LAG:  p1 = ONE_Q32 - xq;
			default:    p1 = xq;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer: P0, then P1 (which seeds the row), then the cells
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		src_v    = 1'b0;
		src_val  = '0;
		src_idx  = '0;
		src_last = 1'b0;
		src_sat  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (sample.valid) begin
					state_d = S_P0;
				end
			end
			S_P0: begin
				src_v    = 1'b1;
				src_val  = ONE_Q32;
				src_last = (d_eff == '0);
				if (adv) begin
					state_d = src_last ? S_IDLE : S_P1;
				end
			end
			S_P1: begin
				src_v    = 1'b1;
				src_val  = p1;
				src_idx  = IDX_W'(1);
				src_last = (d_eff == DEG_W'(1));
				if (adv) begin
					state_d = src_last ? S_IDLE : S_RUN;
				end
			end
			S_RUN: begin
				// only one token is in the row, so at most one cell offers
				for (int k = 2; k <= MAX_DEGREE; k++) begin
					if (tok_o[k].valid) begin
						src_v    = 1'b1;
						src_val  = tok_o[k].cur;
						src_idx  = IDX_W'(k);
						src_last = (d_eff == DEG_W'(k));
						src_sat  = tok_o[k].sat;
					end
				end
				if (adv && src_v && src_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// seed token for the first cell: cur = P1, prev = P0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_v_q <= 1'b0;
		end else if (adv) begin
			seed_v_q <= (state_q == S_P1) && (d_eff != DEG_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seed_cur_q <= p1;
		end
	end

	assign seed = '{valid: seed_v_q, cur: seed_cur_q, prev: ONE_Q32, sat: 1'b0};

	//------------------------------------------------------------------
	// Cell row: cell g produces P(g) from step j = g-1 of the recurrence.
	// The token stops at the cell of the configured top degree.
	//------------------------------------------------------------------
	for (genvar g = 2; g <= MAX_DEGREE; g++) begin : g_cell
		localparam logic [63:0] JJ  = 64'(g - 1);
		localparam logic [63:0] DEN = JJ + 64'd1;
		localparam logic [63:0] LG  = (((64'd2 * JJ + 64'd1) << Q_FRAC) + DEN / 64'd2) / DEN;
		localparam logic [63:0] GM  = ((JJ << Q_FRAC) + DEN / 64'd2) / DEN;
		localparam logic [63:0] IV  = ((64'd1 << Q_FRAC) + DEN / 64'd2) / DEN;

		assign cf[g] = '{j: DEG_W'(g - 1), lg_al: LG[Q_W-1:0], gam: GM[Q_W-1:0],
			inv: IV[Q_W-1:0]};

		if (g == 2) begin : g_first
			assign tok_i[g] = seed;
		end else begin : g_next
			assign tok_i[g] = '{valid: tok_o[g-1].valid && (d_eff != DEG_W'(g - 1)),
				cur: tok_o[g-1].cur, prev: tok_o[g-1].prev, sat: tok_o[g-1].sat};
		end

		opb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.basis  (basis),
			.x      (x_q),
			.coef   (cf[g]),
			.tok_i  (tok_i[g]),
			.tok_o  (tok_o[g])
		);

		assign cell_vld[g] = tok_o[g].valid;
	end

	//------------------------------------------------------------------
	// Output register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= src_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && src_v) begin
			poly_q <= src_val;
			idx_q  <= src_idx;
			last_q <= src_last;
			sat_q  <= src_sat;
		end
	end

	assign result.valid        = out_v_q;
	assign result.poly_value   = poly_q;
	assign result.degree_index = idx_q;
	assign result.last         = last_q;
	assign result.saturated    = sat_q;

	//------------------------------------------------------------------
	// Checks
	//------------------------------------------------------------------
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_vld))
		else $error("more than one token in the cell row");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!(|cell_vld) && !seed_v_q))
		else $error("cell row busy while a sample can be taken");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && src_v && src_last) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after top degree");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import opb_pkg::*;

	// unused basis codes, expected to act as Chebyshev
	localparam logic [BASIS_W-1:0] BASIS_SPARE_5 = 3'd5;
	localparam logic [BASIS_W-1:0] BASIS_SPARE_6 = 3'd6;
	localparam logic [BASIS_W-1:0] BASIS_SPARE_7 = 3'd7;

	// handy Q8.24 points
	localparam logic signed [X_W-1:0] X_ONE      = 32'sh0100_0000;
	localparam logic signed [X_W-1:0] X_NEG_HALF = 32'shFF80_0000;
	localparam logic signed [X_W-1:0] X_MAX      = 32'sh7FFF_FFFF;
	localparam logic signed [X_W-1:0] X_MIN      = 32'sh8000_0000;
	localparam logic signed [X_W-1:0] X_ZERO     = 32'sh0000_0000;

	// one expected basis value
	typedef struct {
		logic signed [P_W-1:0] poly;
		logic [IDX_W-1:0]      idx;
		logic                  last;
		logic                  sat;
	} poly_item_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	opb_in_if  sample_if ();
	opb_out_if result_if ();

	orthopoly_basis_evaluator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor's copy of the two registers
	logic [BASIS_W-1:0]  basis_reg;
	logic [DEGREE_W-1:0] degree_reg;

	// values still owed by the block, oldest first
	poly_item_t expected_poly[$];

	int  errors    = 0;
	int  n_samples = 0;
	int  n_checked = 0;
	int  n_clipped = 0;
	bit  no_idle;

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// hard stop well beyond the slowest legitimate run
	initial begin
		#10_000_000;
		$display("** orthopoly_basis_evaluator: FAILED **");
		$finish;
	end

	// result side back-pressure: ready low about ten percent of the time, never under no_idle
	always @(negedge clk) begin
		result_if.ready <= no_idle || ($urandom_range(0, 99) >= 10);
	end

	task automatic report_mismatch(input string what, input logic [P_W-1:0] got,
		input logic [P_W-1:0] want, input int deg);
		$display("MISMATCH at %0t: %s got %h expected %h (degree %0d)",
			$realtime, what, got, want, deg);
		errors++;
	endtask

	// round(n * 2^30 / d), magnitude only
	function automatic longint q30_div(input longint unsigned n, input longint unsigned d);
		return longint'(((n << Q_FRAC) + d / 2) / d);
	endfunction

	// Work out P0..Pd for one sample under the current registers and queue them.
	task automatic predict_row(input logic signed [X_W-1:0] x);
		basis_t fam;
		int     top;
		int     j;
		longint xs, prev, cur, al, be, ga, t, a1, b1, k, one;
		logic signed [127:0] tw, cw, gw, pw, acc, rsh;
		logic sat;
		poly_item_t e;
		fam  = (basis_reg <= BASIS_LAG) ? basis_t'(basis_reg) : BASIS_CHEB;
		top  = degree_reg;
		one  = 64'sd1 <<< Q_FRAC;
		xs   = x;
		prev = 0;
		cur  = ONE_Q32;
		sat  = 1'b0;
		for (j = 0; j <= top; j++) begin
			if (j == 1) begin
				// P1 is exact: x widened to Q32.32, scaled and offset
				case (fam)
					BASIS_HERM: begin a1 = 2;  b1 = 0; end
					BASIS_LAG:  begin a1 = -1; b1 = 1; end
					default:    begin a1 = 1;  b1 = 0; end
				endcase
				prev = cur;
				cur  = a1 * (xs <<< (HALF_W - X_FRAC_BITS)) + b1 * ONE_Q32;
			end else if (j >= 2) begin
				k  = j - 1;
				be = 0;
				case (fam)
					BASIS_LEG: begin
						al = q30_div(2 * k + 1, k + 1);
						ga = -q30_div(k, k + 1);
					end
					BASIS_HERM: begin
						al = 2 * one;
						ga = -2 * k * one;
					end
					BASIS_HERME: begin
						al = one;
						ga = -k * one;
					end
					BASIS_LAG: begin
						al = -q30_div(1, k + 1);
						be = q30_div(2 * k + 1, k + 1);
						ga = -q30_div(k, k + 1);
					end
					default: begin
						al = 2 * one;
						ga = -one;
					end
				endcase
				// alpha*x rounded half up to Q.30, then beta
				t   = ((al * xs + (64'sd1 <<< (X_FRAC_BITS - 1))) >>> X_FRAC_BITS) + be;
				tw  = t;
				cw  = cur;
				gw  = ga;
				pw  = prev;
				acc = tw * cw + gw * pw + (128'sd1 <<< (Q_FRAC - 1));
				rsh = acc >>> Q_FRAC;
				prev = cur;
				if ((rsh[127:63] == '0) || (rsh[127:63] == '1)) begin
					cur = rsh[63:0];
				end else begin
					sat = 1'b1;
					cur = rsh[127] ? P_MIN : P_MAX;
				end
			end
			e.poly = cur;
			e.idx  = j[IDX_W-1:0];
			e.last = (j == top);
			e.sat  = sat;
			expected_poly.push_back(e);
		end
	endtask

	// Offer one sample; returns at the falling edge after it is taken, valid still high.
	task automatic send_sample(input logic signed [X_W-1:0] x);
		while (!no_idle && $urandom_range(0, 99) < 10) begin
			sample_if.valid <= 1'b0;
			@(negedge clk);
		end
		sample_if.valid   <= 1'b1;
		sample_if.x_value <= x;
		do @(posedge clk); while (!sample_if.ready);
		predict_row(x);
		n_samples++;
		@(negedge clk);
	endtask

	// Drop valid and wait for every owed value; the block is idle afterwards.
	task automatic wait_rows_done();
		sample_if.valid <= 1'b0;
		while (expected_poly.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	// APB write: setup then access; entered and left at a falling edge.
	task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_BASIS)
			basis_reg = val[BASIS_W-1:0];
		else
			degree_reg = val[DEGREE_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_mode(input logic [BASIS_W-1:0] b, input logic [DEGREE_W-1:0] d);
		wait_rows_done();
		apb_write(REG_BASIS, PDATA_W'(b));
		apb_write(REG_DEGREE, PDATA_W'(d));
	endtask

	// Mix of full-range points, points in the usual [-2, 2] window, and corners.
	function automatic logic signed [X_W-1:0] rand_x();
		logic signed [X_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
			2: v = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			default: begin
				case ($urandom_range(0, 4))
					0: v = X_MAX;
					1: v = X_MIN;
					2: v = X_ZERO;
					3: v = X_ONE;
					default: v = -X_ONE;
				endcase
			end
		endcase
		return v;
	endfunction

	// Checker: every accepted value against the oldest prediction.
	always @(posedge clk) begin : check_results
		poly_item_t e;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_poly.size() == 0) begin
				report_mismatch("unexpected item", result_if.poly_value, '0,
					result_if.degree_index);
			end else begin
				e = expected_poly.pop_front();
				n_checked++;
				if (result_if.saturated)
					n_clipped++;
				if (result_if.poly_value !== e.poly)
					report_mismatch("poly_value", result_if.poly_value, e.poly, e.idx);
				if (result_if.degree_index !== e.idx)
					report_mismatch("degree_index", P_W'(result_if.degree_index),
						P_W'(e.idx), e.idx);
				if (result_if.last !== e.last)
					report_mismatch("last", P_W'(result_if.last), P_W'(e.last), e.idx);
				if (result_if.saturated !== e.sat)
					report_mismatch("saturated", P_W'(result_if.saturated),
						P_W'(e.sat), e.idx);
			end
		end
	end

	// Registers at reset: Chebyshev, degree 0, so one value per sample.
	task automatic test_reset_state();
		send_sample(X_ZERO);
		send_sample(X_MAX);
		send_sample(X_MIN);
	endtask

	// Full row of every family at two ordinary points.
	task automatic test_families();
		basis_t fams[5];
		int i;
		fams = '{BASIS_CHEB, BASIS_LEG, BASIS_HERM, BASIS_HERME, BASIS_LAG};
		for (i = 0; i < 5; i++) begin
			set_mode(fams[i], DEGREE_W'(MAX_DEGREE));
			send_sample(X_ONE);
			send_sample(X_NEG_HALF);
		end
	endtask

	// Codes 5..7 must fall back to Chebyshev.
	task automatic test_spare_codes();
		set_mode(BASIS_SPARE_5, 5'd5);
		send_sample(32'sh0180_0000);
		set_mode(BASIS_SPARE_6, 5'd5);
		send_sample(32'shFE40_0000);
		set_mode(BASIS_SPARE_7, 5'd5);
		send_sample(32'sh0080_0000);
	endtask

	// Large x at top degree drives the recurrence into the clip at both ends;
	// the flag must stick for the rest of the row.
	task automatic test_clipping();
		set_mode(BASIS_HERM, DEGREE_W'(MAX_DEGREE));
		send_sample(X_MAX);
		send_sample(X_MIN);
		set_mode(BASIS_CHEB, DEGREE_W'(MAX_DEGREE));
		send_sample(X_MAX);
		// degree 1: P1 of the widest point still fits
		set_mode(BASIS_HERM, 5'd1);
		send_sample(X_MIN);
	endtask

	// Random phases over the five families, then random codes, and a spread of degrees.
	task automatic test_random();
		int p;
		int n;
		logic [BASIS_W-1:0]  b;
		logic [DEGREE_W-1:0] d;
		for (p = 0; p < 12; p++) begin
			b = (p < 5) ? BASIS_W'(p) : BASIS_W'($urandom_range(0, 7));
			case (p % 4)
				0: d = DEGREE_W'($urandom_range(0, 3));
				1: d = DEGREE_W'($urandom_range(2, 10));
				2: d = DEGREE_W'(MAX_DEGREE);
				default: d = DEGREE_W'($urandom_range(0, 31));
			endcase
			if (p == 8)
				d = 5'd0;
			set_mode(b, d);
			no_idle = (p == 6);
			for (n = 0; n < 21; n++) begin
				// hold off once mid-phase until the block has emptied
				if (p == 3 && n == 10)
					wait_rows_done();
				send_sample(rand_x());
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		sample_if.valid   = 1'b0;
		sample_if.x_value = '0;
		basis_reg         = BASIS_CHEB;
		degree_reg        = '0;
		no_idle           = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_families();
		test_spare_codes();
		test_clipping();
		test_random();

		wait_rows_done();
		// long enough for a stray row at top degree to show up
		repeat (100) @(negedge clk);

		$display("Run covered %0d samples and %0d checked values, %0d of them clipped,",
			n_samples, n_checked, n_clipped);
		$display("over all five families, the spare basis codes and degrees 0 to %0d.",
			MAX_DEGREE);
		if (errors == 0) begin
			$display("** orthopoly_basis_evaluator: PASSED **");
		end else begin
			$display("** orthopoly_basis_evaluator: FAILED **");
		end
		$finish;
	end

endmodule
